### src/tai_pkg.sv
// tai_pkg: shared types and constants for the timestamp align interpolator
// used by tai_lane, timestamp_align_interpolator_core and the testbench, no dependencies
package tai_pkg;

	localparam int FIX_DEPTH_DEF = 1024;
	localparam int POS_BITS_DEF  = 32;
	localparam int W             = 32;

	localparam logic [1:0] KIND_FIX    = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEEK,
		ST_CHECK,
		ST_PREV,
		ST_CALC
	} state_t;

	typedef enum logic [1:0] {
		LN_IDLE,
		LN_MUL,
		LN_DIV,
		LN_FIN
	} lane_state_t;

	// one table entry: fix time and position
	typedef struct packed {
		logic [W-1:0] tm;
		logic [W-1:0] px;
		logic [W-1:0] py;
		logic [W-1:0] pz;
	} entry_t;

	// bracket geometry shared by all lanes
	typedef struct packed {
		logic         den_zero;
		logic         neg;
		logic [W-1:0] dt_mag;
		logic [W-1:0] den_mag;
	} lane_req_t;

endpackage

### src/tai_lane.sv
// tai_lane: one axis of the interpolator, multiply, serial divide, saturate
// depends on tai_pkg
module tai_lane #(
	parameter int POS_BITS = tai_pkg::POS_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  tai_pkg::lane_req_t      req,
	input  logic [tai_pkg::W-1:0]   prev,
	input  logic [tai_pkg::W-1:0]   next,
	output logic                    done,
	output logic [tai_pkg::W-1:0]   pos
);

	localparam int W  = tai_pkg::W;
	localparam int LB = (POS_BITS < W) ? POS_BITS : W;
	localparam int SW = W + 3;
	localparam logic [SW-1:0] HI_LIM = (SW'(1) << (LB - 1)) - SW'(1);
	localparam logic [SW-1:0] LO_LIM = ~HI_LIM;

	tai_pkg::lane_state_t state_q, state_d;
	tai_pkg::lane_req_t   req_q;
	logic [W-1:0]         prev_q;
	logic [W-1:0]         dmag_q;
	logic                 neg_q;
	logic [2*W-1:0]       n_q;
	logic [W-1:0]         rem_q;
	logic [4:0]           cnt_q;
	logic                 done_q;
	logic [W-1:0]         pos_q;

	logic signed [W:0]    dpos;
	logic [W-1:0]         dpos_mag;
	logic [2*W-1:0]       n_nx;
	logic [W-1:0]         rem_nx;
	logic signed [SW-1:0] sum;
	logic [W-1:0]         sat;

	// position difference and its magnitude
	always_comb begin
		dpos = $signed({next[W-1], next}) - $signed({prev[W-1], prev});
		dpos_mag = dpos[W] ? W'(-dpos) : dpos[W-1:0];
	end

	// two restoring divide steps per cycle
	always_comb begin
		logic [W:0]     r;
		logic [2*W-1:0] n;
		r = {1'b0, rem_q};
		n = n_q;
		for (int i = 0; i < 2; i++) begin
			r = {r[W-1:0], n[2*W-1]};
			n = {n[2*W-2:0], 1'b0};
			if (r >= {1'b0, req_q.den_mag}) begin
				r = r - {1'b0, req_q.den_mag};
				n[0] = 1'b1;
			end
		end
		rem_nx = r[W-1:0];
		n_nx = n;
	end

	// add quotient to prev and clamp to the position range
	always_comb begin
		sum = SW'($signed(prev_q));
		sat = '0;
		if (!req_q.den_zero && n_q[2*W-1:W+1] != '0) begin
			sat = neg_q ? W'(LO_LIM) : W'(HI_LIM);
		end else begin
			// equal bracket times keep prev, still clamped
			if (!req_q.den_zero) begin
				if (neg_q) begin
					sum = $signed(SW'($signed(prev_q))) - $signed({2'b00, n_q[W:0]});
				end else begin
					sum = $signed(SW'($signed(prev_q))) + $signed({2'b00, n_q[W:0]});
				end
			end
			if (sum > $signed(HI_LIM)) begin
				sat = W'(HI_LIM);
			end else if (sum < $signed(LO_LIM)) begin
				sat = W'(LO_LIM);
			end else begin
				sat = sum[W-1:0];
			end
		end
	end

	// lane sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			tai_pkg::LN_IDLE: begin
				if (start) state_d = tai_pkg::LN_MUL;
			end
			tai_pkg::LN_MUL: begin
				state_d = req_q.den_zero ? tai_pkg::LN_FIN : tai_pkg::LN_DIV;
			end
			tai_pkg::LN_DIV: begin
				if (cnt_q == 5'd31) state_d = tai_pkg::LN_FIN;
			end
			tai_pkg::LN_FIN: begin
				state_d = tai_pkg::LN_IDLE;
			end
			default: state_d = tai_pkg::LN_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tai_pkg::LN_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == tai_pkg::LN_FIN);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tai_pkg::LN_IDLE: begin
				if (start) begin
					req_q <= req;
					prev_q <= prev;
					dmag_q <= dpos_mag;
					neg_q <= req.neg ^ dpos[W];
				end
			end
			tai_pkg::LN_MUL: begin
				n_q <= dmag_q * req_q.dt_mag;
				rem_q <= '0;
				cnt_q <= '0;
			end
			tai_pkg::LN_DIV: begin
				n_q <= n_nx;
				rem_q <= rem_nx;
				cnt_q <= cnt_q + 5'd1;
			end
			tai_pkg::LN_FIN: begin
				pos_q <= sat;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign pos = pos_q;

endmodule

### src/timestamp_align_interpolator_core.sv
// timestamp_align_interpolator_core: fix table, bracket search, three lanes; uses tai_pkg, tai_lane
// Sequence: a fix, clear or ignored request is handled on acceptance and leaves busy low; a
// sample that finds a later fix strobes its result after a seek and a check per fix the cursor
// passes, lane start, multiply, serial divide, saturation and merge; equal bracket times skip
// the divide. Throughput: one sample at a time; the receiver cannot stall.
// Reset clears fix count, cursor, overflow flag and control; table is not cleared.
module timestamp_align_interpolator_core #(
	parameter int FIX_DEPTH = tai_pkg::FIX_DEPTH_DEF,
	parameter int POS_BITS  = tai_pkg::POS_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  kind,
	input  logic [31:0]                 sample_time,
	input  logic signed [31:0]          value_x,
	input  logic signed [31:0]          value_y,
	input  logic signed [31:0]          value_z,
	output logic                        result_valid,
	output logic [31:0]                 out_time,
	output logic signed [31:0]          accel_x,
	output logic signed [31:0]          accel_y,
	output logic signed [31:0]          accel_z,
	output logic signed [31:0]          pos_x,
	output logic signed [31:0]          pos_y,
	output logic signed [31:0]          pos_z,
	output logic                        table_overflowed
);

	localparam int W  = tai_pkg::W;
	localparam int AW = $clog2(FIX_DEPTH);
	localparam logic [AW:0] DEPTH_C = (AW+1)'(FIX_DEPTH);

	tai_pkg::state_t    state_q, state_d;
	tai_pkg::entry_t    mem [FIX_DEPTH];
	tai_pkg::entry_t    rd_q;
	tai_pkg::entry_t    next_q;
	logic [AW-1:0]      rd_addr;
	logic [AW:0]        count_q;
	logic [AW-1:0]      cursor_q;
	logic               ovf_q;
	logic [W-1:0]       t_q;
	logic [W-1:0]       ax_q, ay_q, az_q;
	logic               accept;
	logic [AW:0]        cur_p1;
	logic               lane_start;
	logic [2:0]         lane_done;
	logic [W-1:0]       lane_pos [3];
	tai_pkg::lane_req_t req;
	logic signed [W:0]  dt, den;
	logic               valid_q;
	logic [W-1:0]       otime_q, oax_q, oay_q, oaz_q, opx_q, opy_q, opz_q;
	logic               oovf_q;

	assign accept = start && !busy;
	assign busy = (state_q != tai_pkg::ST_IDLE);
	assign cur_p1 = {1'b0, cursor_q} + (AW+1)'(1);

	// bracket geometry from prev entry (read data) and next entry
	always_comb begin
		dt = $signed({1'b0, t_q}) - $signed({1'b0, rd_q.tm});
		den = $signed({1'b0, next_q.tm}) - $signed({1'b0, rd_q.tm});
		req.den_zero = (den == '0);
		req.neg = dt[W] ^ den[W];
		req.dt_mag = dt[W] ? W'(-dt) : dt[W-1:0];
		req.den_mag = den[W] ? W'(-den) : den[W-1:0];
	end

	// next state and read address
	always_comb begin
		state_d = state_q;
		rd_addr = cursor_q;
		lane_start = 1'b0;
		case (state_q)
			tai_pkg::ST_IDLE: begin
				if (accept && kind == tai_pkg::KIND_SAMPLE) state_d = tai_pkg::ST_SEEK;
			end
			tai_pkg::ST_SEEK: begin
				rd_addr = cur_p1[AW-1:0];
				state_d = (cur_p1 < count_q) ? tai_pkg::ST_CHECK : tai_pkg::ST_IDLE;
			end
			tai_pkg::ST_CHECK: begin
				rd_addr = cursor_q;
				state_d = (rd_q.tm <= t_q) ? tai_pkg::ST_SEEK : tai_pkg::ST_PREV;
			end
			tai_pkg::ST_PREV: begin
				lane_start = 1'b1;
				state_d = tai_pkg::ST_CALC;
			end
			tai_pkg::ST_CALC: begin
				if (&lane_done) state_d = tai_pkg::ST_IDLE;
			end
			default: state_d = tai_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tai_pkg::ST_IDLE;
			count_q <= '0;
			cursor_q <= '0;
			ovf_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= (state_q == tai_pkg::ST_CALC) && (&lane_done);
			if (accept && kind == tai_pkg::KIND_FIX) begin
				if (count_q < DEPTH_C) count_q <= count_q + (AW+1)'(1);
				else ovf_q <= 1'b1;
			end
			if (accept && kind == tai_pkg::KIND_CLEAR) begin
				count_q <= '0;
				cursor_q <= '0;
				ovf_q <= 1'b0;
			end
			if (state_q == tai_pkg::ST_CHECK && rd_q.tm <= t_q) begin
				cursor_q <= cur_p1[AW-1:0];
			end
		end
	end

	// fix table, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (accept && kind == tai_pkg::KIND_FIX && count_q < DEPTH_C) begin
			mem[count_q[AW-1:0]] <= {sample_time, value_x, value_y, value_z};
		end
		rd_q <= mem[rd_addr];
	end

	// sample request and bracket holding registers
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q <= sample_time;
			ax_q <= value_x;
			ay_q <= value_y;
			az_q <= value_z;
		end
		if (state_q == tai_pkg::ST_CHECK) next_q <= rd_q;
	end

	tai_lane #(.POS_BITS(POS_BITS)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .start(lane_start), .req(req),
		.prev(rd_q.px), .next(next_q.px), .done(lane_done[0]), .pos(lane_pos[0])
	);
	tai_lane #(.POS_BITS(POS_BITS)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .start(lane_start), .req(req),
		.prev(rd_q.py), .next(next_q.py), .done(lane_done[1]), .pos(lane_pos[1])
	);
	tai_lane #(.POS_BITS(POS_BITS)) u_lane_z (
		.clk(clk), .arst_n(arst_n), .start(lane_start), .req(req),
		.prev(rd_q.pz), .next(next_q.pz), .done(lane_done[2]), .pos(lane_pos[2])
	);

	// merge lane results into the output register
	always_ff @(posedge clk) begin
		if (state_q == tai_pkg::ST_CALC && (&lane_done)) begin
			otime_q <= t_q;
			oax_q <= ax_q;
			oay_q <= ay_q;
			oaz_q <= az_q;
			opx_q <= lane_pos[0];
			opy_q <= lane_pos[1];
			opz_q <= lane_pos[2];
			oovf_q <= ovf_q;
		end
	end

	assign result_valid = valid_q;
	assign out_time = otime_q;
	assign accel_x = oax_q;
	assign accel_y = oay_q;
	assign accel_z = oaz_q;
	assign pos_x = opx_q;
	assign pos_y = opy_q;
	assign pos_z = opz_q;
	assign table_overflowed = oovf_q;

	// lanes run in lockstep
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> (lane_done[1] && lane_done[2]))
		else $error("lanes out of step");

	// a result strobe is never held high
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held");

	// cursor stays inside the filled part of the table
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cursor_q == '0) || ({1'b0, cursor_q} < count_q))
		else $error("cursor beyond fix count");

	// overflow only once the table is full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == DEPTH_C))
		else $error("overflow with free entries");

endmodule

### test/timestamp_align_interpolator_core_tb.sv
// testbench for timestamp_align_interpolator_core: fix loading, clears and sample alignment
// checks results against a scoreboard class that predicts the interpolation; needs tai_pkg
`timescale 1ns / 1ps

module timestamp_align_interpolator_core_tb;

	localparam int DEPTH = 1024;
	localparam int PBITS = 32;
	localparam logic [1:0] KIND_IGNORED = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [31:0] tm;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] az;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic        ovf;
	} aligned_t;

	class align_scoreboard;
		logic [31:0] fx_t [DEPTH];
		logic [31:0] fx_x [DEPTH];
		logic [31:0] fx_y [DEPTH];
		logic [31:0] fx_z [DEPTH];
		int unsigned count;
		int unsigned cursor;
		bit ovf;
		aligned_t pending [$];
		int errors;
		int checked;

		function void clear_state();
			count = 0;
			cursor = 0;
			ovf = 0;
		endfunction

		// one axis of the interpolation, exact in 128 bits, then saturated
		function logic [31:0] lerp(logic [31:0] p_raw, logic [31:0] n_raw,
				longint dt, longint den);
			longint prv;
			longint dpos;
			logic signed [127:0] prod;
			logic signed [127:0] quo;
			logic signed [127:0] res;
			logic signed [127:0] hi_lim;
			prv = longint'($signed(p_raw));
			dpos = longint'($signed(n_raw)) - prv;
			hi_lim = (128'sd1 <<< (PBITS - 1)) - 1;
			if (den == 0) begin
				res = prv;
			end else begin
				prod = 128'(dpos) * 128'(dt);
				quo = prod / 128'(den);
				res = 128'(prv) + quo;
			end
			if (res > hi_lim) res = hi_lim;
			if (res < -hi_lim - 1) res = -hi_lim - 1;
			return res[31:0];
		endfunction

		// note one accepted request
		function void note_request(logic [1:0] k, logic [31:0] t, logic [31:0] vx,
				logic [31:0] vy, logic [31:0] vz);
			aligned_t e;
			longint dt;
			longint den;
			if (k == tai_pkg::KIND_FIX) begin
				if (count < DEPTH) begin
					fx_t[count] = t;
					fx_x[count] = vx;
					fx_y[count] = vy;
					fx_z[count] = vz;
					count++;
				end else begin
					ovf = 1;
				end
			end else if (k == tai_pkg::KIND_CLEAR) begin
				clear_state();
			end else if (k == tai_pkg::KIND_SAMPLE) begin
				while (cursor + 1 < count && fx_t[cursor + 1] <= t) cursor++;
				if (cursor + 1 < count) begin
					dt = longint'(t) - longint'(fx_t[cursor]);
					den = longint'(fx_t[cursor + 1]) - longint'(fx_t[cursor]);
					e.tm = t;
					e.ax = vx;
					e.ay = vy;
					e.az = vz;
					e.px = lerp(fx_x[cursor], fx_x[cursor + 1], dt, den);
					e.py = lerp(fx_y[cursor], fx_y[cursor + 1], dt, den);
					e.pz = lerp(fx_z[cursor], fx_z[cursor + 1], dt, den);
					e.ovf = ovf;
					pending = {pending, e};
				end
			end
		endfunction

		// compare one strobed result with the oldest prediction
		function void check_result(aligned_t got);
			aligned_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.tm != e.tm) report("out_time", e.tm, got.tm);
			if (got.ax != e.ax) report("accel_x", e.ax, got.ax);
			if (got.ay != e.ay) report("accel_y", e.ay, got.ay);
			if (got.az != e.az) report("accel_z", e.az, got.az);
			if (got.px != e.px) report("pos_x", e.px, got.px);
			if (got.py != e.py) report("pos_y", e.py, got.py);
			if (got.pz != e.pz) report("pos_z", e.pz, got.pz);
			if (got.ovf != e.ovf) report("table_overflowed", 32'(e.ovf), 32'(got.ovf));
		endfunction

		function void report(string f, logic [31:0] exp_v, logic [31:0] act_v);
			$display("%0t: %s mismatch expected %h actual %h", $realtime, f, exp_v, act_v);
			errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] kind;
	logic [31:0] sample_time;
	logic signed [31:0] value_x;
	logic signed [31:0] value_y;
	logic signed [31:0] value_z;
	logic result_valid;
	logic [31:0] out_time;
	logic signed [31:0] accel_x;
	logic signed [31:0] accel_y;
	logic signed [31:0] accel_z;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic table_overflowed;

	align_scoreboard sb;
	int cycles;
	int n_requests;
	int n_fix;
	int n_sample;
	logic [31:0] fix_clock;
	logic [31:0] smp_clock;

	timestamp_align_interpolator_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.sample_time(sample_time), .value_x(value_x), .value_y(value_y),
		.value_z(value_z), .result_valid(result_valid), .out_time(out_time),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .pos_x(pos_x),
		.pos_y(pos_y), .pos_z(pos_z), .table_overflowed(table_overflowed)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result monitor and cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && result_valid)
			sb.check_result({out_time, accel_x, accel_y, accel_z, pos_x, pos_y, pos_z,
				table_overflowed});
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// short gaps mostly, a few long ones; start drops during a gap
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			start <= 0;
			repeat (n) @(negedge clk);
		end
	endtask

	// issue one request and wait for it to be taken; start stays up for the caller
	task automatic send(logic [1:0] k, logic [31:0] t, logic [31:0] vx,
			logic [31:0] vy, logic [31:0] vz);
		kind <= k;
		sample_time <= t;
		value_x <= vx;
		value_y <= vy;
		value_z <= vz;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(k, t, vx, vy, vz);
		n_requests++;
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			default: return $urandom_range(0, 20000) - 10000;
		endcase
	endfunction

	// well-formed track: a few fixes then samples across them
	task automatic run_track();
		int nf;
		int ns;
		nf = $urandom_range(2, 6);
		ns = $urandom_range(2, 8);
		send(tai_pkg::KIND_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
		idle_gap();
		fix_clock = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 5000);
		smp_clock = fix_clock - $urandom_range(0, 50);
		repeat (nf) begin
			send(tai_pkg::KIND_FIX, fix_clock, rand_pos(), rand_pos(), rand_pos());
			n_fix++;
			fix_clock = fix_clock + (($urandom_range(0, 5) == 0) ? 0 :
				(($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 400)));
			idle_gap();
		end
		repeat (ns) begin
			send(tai_pkg::KIND_SAMPLE, smp_clock, $urandom(), $urandom(), $urandom());
			n_sample++;
			smp_clock = smp_clock + $urandom_range(0, 300);
			idle_gap();
		end
	endtask

	initial begin
		sb = new();
		sb.clear_state();
		cycles = 0;
		n_requests = 0;
		n_fix = 0;
		n_sample = 0;
		arst_n = 0;
		start = 0;
		kind = tai_pkg::KIND_FIX;
		sample_time = 0;
		value_x = 0;
		value_y = 0;
		value_z = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: too few fixes, extrapolation before first fix, extremes
		send(tai_pkg::KIND_SAMPLE, 32'd5, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
		send(tai_pkg::KIND_FIX, 32'd100, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
		send(tai_pkg::KIND_SAMPLE, 32'd100, 32'd1, 32'd2, 32'd3);
		send(tai_pkg::KIND_FIX, 32'd200, 32'h7fff_ffff, 32'h8000_0000, 32'd1000);
		send(tai_pkg::KIND_SAMPLE, 32'd0, 32'hffff_ffff, 32'd0, 32'd1);
		send(tai_pkg::KIND_SAMPLE, 32'd150, 32'd4, 32'd5, 32'd6);
		send(tai_pkg::KIND_SAMPLE, 32'd199, 32'd4, 32'd5, 32'd6);
		send(tai_pkg::KIND_SAMPLE, 32'd200, 32'd7, 32'd8, 32'd9);
		send(KIND_IGNORED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		// equal bracket times and decreasing times
		send(tai_pkg::KIND_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0);
		send(tai_pkg::KIND_FIX, 32'd50, 32'd10, 32'd20, 32'd30);
		send(tai_pkg::KIND_FIX, 32'd50, 32'd90, 32'd80, 32'd70);
		send(tai_pkg::KIND_FIX, 32'd10, 32'd0, -32'sd500, 32'd7);
		send(tai_pkg::KIND_FIX, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
		send(tai_pkg::KIND_SAMPLE, 32'd50, 32'd0, 32'd0, 32'd0);
		send(tai_pkg::KIND_SAMPLE, 32'hffff_fffe, 32'd0, 32'd0, 32'd0);
		send(tai_pkg::KIND_SAMPLE, 32'hffff_ffff, 32'd0, 32'd0, 32'd0);
		drain();

		// table overflow: fill the whole table and one beyond
		send(tai_pkg::KIND_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0);
		for (int i = 0; i <= DEPTH; i++)
			send(tai_pkg::KIND_FIX, i * 3, rand_pos(), rand_pos(), rand_pos());
		send(tai_pkg::KIND_SAMPLE, 32'd1, 32'd1, 32'd1, 32'd1);
		send(tai_pkg::KIND_SAMPLE, 32'd3 * (DEPTH - 2) + 1, 32'd1, 32'd1, 32'd1);
		drain();

		// random tracks, with some noise requests
		while (n_requests < 1150) begin
			if ($urandom_range(0, 9) == 0)
				send(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
					$urandom());
			else
				run_track();
			if ($urandom_range(0, 19) == 0) drain();
		end
		drain();

		$display("ran %0d requests (%0d track fixes, %0d track samples), %0d results checked",
			n_requests, n_fix, n_sample, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
src/tai_pkg.sv
src/tai_lane.sv
src/timestamp_align_interpolator_core.sv
test/timestamp_align_interpolator_core_tb.sv
